// ===== sv/bdlp_pkg.sv =====
// Package for the button debouncer with long-press detection.
// Holds the beat payload types, the register map and the reset constants.
// No dependencies.
package bdlp_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [CfgW-1:0] DebounceReset = 16'd50;
  localparam logic [CfgW-1:0] HoldReset     = 16'd3000;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_HOLD     = 1'b1
  } reg_idx_e;

  localparam logic LevelPressed  = 1'b0;
  localparam logic LevelReleased = 1'b1;

  typedef struct packed {
    logic             raw_level;
    logic [TimeW-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic press_event;
    logic long_hold;
  } out_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] hold_ms;
  } cfg_t;

endpackage

// ===== sv/bdlp_core.sv =====
// Debounce and long-hold state with its single-pass update logic.
// Depends on bdlp_pkg for the payload and configuration types.
module bdlp_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  bdlp_pkg::in_t  in_i,
  input  bdlp_pkg::cfg_t cfg_i,
  output bdlp_pkg::out_t res_o
);
  import bdlp_pkg::*;

  logic             prev_raw_q, prev_raw_d;
  logic             deb_lvl_q, deb_lvl_d;
  logic [TimeW-1:0] change_stamp_q, change_stamp_d;
  logic [TimeW-1:0] hold_stamp_q, hold_stamp_d;
  logic             hold_flag_q, hold_flag_d;

  logic             changed;
  logic [TimeW-1:0] hold_stamp_eff;
  logic             hold_flag_eff;
  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] since_hold;
  logic             take_level;
  logic             press;

  always_comb begin
    changed        = in_i.raw_level != prev_raw_q;
    hold_stamp_eff = changed ? in_i.now_ms : hold_stamp_q;
    hold_flag_eff  = changed ? 1'b0 : hold_flag_q;
    since_change   = in_i.now_ms - change_stamp_q;
    since_hold     = in_i.now_ms - hold_stamp_eff;
    take_level     = !changed
                     && (since_change > {{(TimeW-CfgW){1'b0}}, cfg_i.debounce_ms})
                     && (in_i.raw_level != deb_lvl_q);
    press          = take_level && (in_i.raw_level == LevelPressed);

    prev_raw_d     = in_i.raw_level;
    change_stamp_d = changed ? in_i.now_ms : change_stamp_q;
    deb_lvl_d      = take_level ? in_i.raw_level : deb_lvl_q;

    if (press) begin
      hold_stamp_d = hold_stamp_eff;
      hold_flag_d  = hold_flag_eff;
    end else if (deb_lvl_d == LevelPressed) begin
      hold_stamp_d = hold_stamp_eff;
      hold_flag_d  = hold_flag_eff
                     || (since_hold >= {{(TimeW-CfgW){1'b0}}, cfg_i.hold_ms});
    end else begin
      hold_stamp_d = in_i.now_ms;
      hold_flag_d  = 1'b0;
    end

    res_o.press_event = press;
    res_o.long_hold   = hold_flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q     <= LevelReleased;
      deb_lvl_q      <= LevelReleased;
      change_stamp_q <= '0;
      hold_stamp_q   <= '0;
      hold_flag_q    <= 1'b0;
    end else if (step_i) begin
      prev_raw_q     <= prev_raw_d;
      deb_lvl_q      <= deb_lvl_d;
      change_stamp_q <= change_stamp_d;
      hold_stamp_q   <= hold_stamp_d;
      hold_flag_q    <= hold_flag_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A released debounced level never carries the long-hold flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (deb_lvl_q == LevelReleased) |-> !hold_flag_q)
    else $error("long-hold flag set while released");

  // A press event starts from a cleared long-hold flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && press) |-> !res_o.long_hold)
    else $error("press event with long-hold flag set");

  // A raw level change restarts the debounce timer at the poll time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && changed) |=> (change_stamp_q == $past(in_i.now_ms)))
    else $error("change stamp not restarted");
`endif

endmodule

// ===== sv/button_debounce_long_press.sv =====
// Top level of the button debouncer with long-press detection.
// Holds the APB register file, the beat handshake and the result register.
// Depends on bdlp_pkg and bdlp_core.
//
//   Channel  Direction  Handshake                  Payload
//   in       receive    in_valid_i / in_stall_o    bdlp_pkg::in_t  (raw_level, now_ms)
//   out      send       out_valid_o / out_stall_i  bdlp_pkg::out_t (press_event, long_hold)
//   config   receive    psel / penable / pready    debounce_ms at 0x0, hold_ms at 0x4
//
// Each beat is processed combinationally and its result appears on the next cycle.
// One beat is accepted every cycle while the result register is free or being drained.
// in_stall_o is high only while a result is held and out_stall_i is high.
// Reset clears the state to released with both stamps at zero and the flag clear.
module button_debounce_long_press (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bdlp_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bdlp_pkg::out_t               out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdlp_pkg::AddrW-1:0]   paddr,
  input  logic [bdlp_pkg::DataW-1:0]   pwdata,
  output logic [bdlp_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import bdlp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  out_t     res;
  out_t     out_data_q;
  logic     out_valid_q, out_valid_d;
  logic     in_accept;
  logic     cfg_write;
  reg_idx_e reg_idx;

  assign pready     = 1'b1;
  assign reg_idx    = reg_idx_e'(paddr[2]);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (reg_idx)
        REG_DEBOUNCE: cfg_d.debounce_ms = pwdata[CfgW-1:0];
        REG_HOLD:     cfg_d.hold_ms     = pwdata[CfgW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = {{(DataW-CfgW){1'b0}}, cfg_q.debounce_ms};
      REG_HOLD:     prdata = {{(DataW-CfgW){1'b0}}, cfg_q.hold_ms};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= DebounceReset;
      cfg_q.hold_ms     <= HoldReset;
      out_valid_q       <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= res;
    end
  end

  bdlp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_accept),
    .in_i   (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // Every accepted beat leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted beat left no result");

  // A held result that is stalled blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input open while result is stalled");

  // A completed write to the debounce register lands on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_write && (reg_idx == REG_DEBOUNCE))
      |=> (cfg_q.debounce_ms == $past(pwdata[CfgW-1:0])))
    else $error("debounce register write lost");
`endif

endmodule

// ===== verif/button_debounce_long_press_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for button_debounce_long_press: directed polls, then random episodes.
// Press and long-hold results come from known rows or the behavioural debouncer in this file.
// Depends on bdlp_pkg and the button_debounce_long_press RTL.
module button_debounce_long_press_tb;
  import bdlp_pkg::*;

  localparam int unsigned NumPhases     = 10;
  localparam int unsigned PollsPerPhase = 123;
  localparam int unsigned PressurePhase = 2;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned StallLimit    = 2000;

  typedef enum logic [1:0] {
    ROW_POLL,
    ROW_KNOWN,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    reg_idx_e        idx;
    logic [CfgW-1:0] val;
    in_t             beat;
    out_t            res;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_t               in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_t              out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  logic              seen_raw;
  logic              db_level;
  logic              hold_set;
  logic [TimeW-1:0]  change_ms;
  logic [TimeW-1:0]  hold_start_ms;
  logic [CfgW-1:0]   db_limit;
  logic [CfgW-1:0]   hold_limit;

  out_t              due_events [$];
  out_t              want;
  row_t              plan [$];
  int                mismatches;
  bit                gaps_on;
  bit                stalls_on;
  bit                hold_off_req;

  button_debounce_long_press uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_t debounce_poll(input in_t beat);
    out_t             res;
    logic [TimeW-1:0] since_change;
    logic [TimeW-1:0] since_hold;
    logic             just_pressed;
    res = '0;
    just_pressed = 1'b0;
    if (beat.raw_level != seen_raw) begin
      change_ms = beat.now_ms;
      hold_start_ms = beat.now_ms;
      hold_set = 1'b0;
    end
    since_change = beat.now_ms - change_ms;
    if (since_change > 32'(db_limit) && beat.raw_level != db_level) begin
      db_level = beat.raw_level;
      if (beat.raw_level == LevelPressed) begin
        res.press_event = 1'b1;
        just_pressed = 1'b1;
      end
    end
    if (!just_pressed) begin
      if (db_level == LevelPressed) begin
        since_hold = beat.now_ms - hold_start_ms;
        if (since_hold >= 32'(hold_limit)) hold_set = 1'b1;
      end else begin
        hold_start_ms = beat.now_ms;
        hold_set = 1'b0;
      end
    end
    seen_raw = beat.raw_level;
    res.long_hold = hold_set;
    return res;
  endfunction

  function automatic row_t poll_row(input logic raw, input logic [TimeW-1:0] now);
    row_t r;
    r = '0;
    r.kind = ROW_POLL;
    r.beat.raw_level = raw;
    r.beat.now_ms = now;
    return r;
  endfunction

  function automatic row_t known_row(input logic raw, input logic [TimeW-1:0] now,
                                     input logic pe, input logic lh);
    row_t r;
    r = poll_row(raw, now);
    r.kind = ROW_KNOWN;
    r.res.press_event = pe;
    r.res.long_hold = lh;
    return r;
  endfunction

  function automatic row_t reg_row(input reg_idx_e idx, input logic [CfgW-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  task automatic offer_poll(input in_t beat, input bit typed, input out_t res);
    out_t model;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model = debounce_poll(beat);
    due_events.push_back(typed ? res : model);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_timer_reg(input reg_idx_e idx, input logic [CfgW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_DEBOUNCE) db_limit = val;
    else hold_limit = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {16'h0, val}) begin
      $display("%0t: register %s read back expected %h got %h", $time, idx.name(),
               {16'h0, val}, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_events.size() == 0) begin
        $display("%0t: result beat %b with nothing expected", $time, out_data_o);
        mismatches++;
      end else begin
        want = due_events.pop_front();
        if (out_data_o.press_event !== want.press_event) begin
          $display("%0t: press_event expected %b got %b", $time, want.press_event,
                   out_data_o.press_event);
          mismatches++;
        end
        if (out_data_o.long_hold !== want.long_hold) begin
          $display("%0t: long_hold expected %b got %b", $time, want.long_hold,
                   out_data_o.long_hold);
          mismatches++;
        end
      end
    end
  end

  initial begin : out_stall_gen
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles - 1) @(posedge clk_i);
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17) - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(0, 30)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) idle = 0;
      else idle++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, idle);
    $display("button_debounce_long_press regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned      ph;
    int unsigned      n;
    int unsigned      left;
    int unsigned      bounce;
    logic             target;
    logic [CfgW-1:0]  dval;
    logic [CfgW-1:0]  hval;
    logic [TimeW-1:0] now;
    in_t              beat;

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    seen_raw = LevelReleased;
    db_level = LevelReleased;
    hold_set = 1'b0;
    change_ms = '0;
    hold_start_ms = '0;
    db_limit = DebounceReset;
    hold_limit = HoldReset;
    mismatches = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_off_req = 1'b0;

    plan.push_back(known_row(LevelReleased, 32'd0, 1'b0, 1'b0));
    plan.push_back(poll_row(LevelPressed, 32'd100));
    plan.push_back(poll_row(LevelPressed, 32'd150));
    plan.push_back(known_row(LevelPressed, 32'd151, 1'b1, 1'b0));
    plan.push_back(known_row(LevelPressed, 32'd3150, 1'b0, 1'b1));
    plan.push_back(poll_row(LevelReleased, 32'hFFFF_FFFF));
    plan.push_back(poll_row(LevelReleased, 32'd50));
    plan.push_back(poll_row(LevelReleased, 32'd10));
    plan.push_back(reg_row(REG_DEBOUNCE, 16'd0));
    plan.push_back(reg_row(REG_HOLD, 16'd0));
    plan.push_back(poll_row(LevelPressed, 32'd1000));
    plan.push_back(known_row(LevelPressed, 32'd1001, 1'b1, 1'b0));
    plan.push_back(known_row(LevelPressed, 32'd1001, 1'b0, 1'b1));
    plan.push_back(poll_row(LevelPressed, 32'd500));
    plan.push_back(poll_row(LevelReleased, 32'd500));
    plan.push_back(poll_row(LevelReleased, 32'd501));
    plan.push_back(poll_row(LevelPressed, 32'hFFFF_FFFF));
    plan.push_back(poll_row(LevelPressed, 32'd0));
    plan.push_back(reg_row(REG_DEBOUNCE, 16'hFFFF));
    plan.push_back(reg_row(REG_HOLD, 16'hFFFF));
    plan.push_back(poll_row(LevelReleased, 32'd0));
    plan.push_back(poll_row(LevelPressed, 32'd16));
    plan.push_back(poll_row(LevelPressed, 32'd65551));
    plan.push_back(poll_row(LevelPressed, 32'd65552));
    plan.push_back(poll_row(LevelPressed, 32'd131086));
    plan.push_back(poll_row(LevelReleased, 32'h8000_0000));
    plan.push_back(poll_row(LevelReleased, 32'h7FFF_FFFF));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_REG: begin
          wait_quiet();
          set_timer_reg(plan[i].idx, plan[i].val);
        end
        ROW_KNOWN: offer_poll(plan[i].beat, 1'b1, plan[i].res);
        default: offer_poll(plan[i].beat, 1'b0, '0);
      endcase
    end

    target = LevelReleased;
    for (ph = 0; ph < NumPhases; ph++) begin
      wait_quiet();
      case ($urandom_range(0, 4))
        0: dval = '0;
        1: dval = '1;
        default: dval = 16'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 4))
        0: hval = '0;
        1: hval = '1;
        default: hval = 16'($urandom_range(1, 300));
      endcase
      set_timer_reg(REG_DEBOUNCE, dval);
      set_timer_reg(REG_HOLD, hval);
      now = $urandom();
      gaps_on = ($urandom_range(0, 3) != 0) && ph != PressurePhase && ph != NumPhases - 1;
      stalls_on = ($urandom_range(0, 3) != 0) && ph != NumPhases - 1;
      if (ph == PressurePhase) hold_off_req = 1'b1;
      left = 0;
      bounce = 0;
      for (n = 0; n < PollsPerPhase; n++) begin
        if (left == 0) begin
          target = ~target;
          bounce = $urandom_range(0, 4);
          left = bounce + $urandom_range(2, 14);
        end
        if (bounce > 0) begin
          beat.raw_level = 1'($urandom_range(0, 1));
          now += $urandom_range(0, dval / 2 + 1);
          bounce--;
        end else begin
          beat.raw_level = ($urandom_range(0, 24) == 0) ? ~target : target;
          case ($urandom_range(0, 9))
            0: now = now;
            1, 2, 3, 4, 5: now += $urandom_range(0, 2 * dval + 2);
            6, 7, 8: now += $urandom_range(0, hval / 4 + 2);
            default: now = ($urandom_range(0, 1) == 1) ? now - $urandom_range(0, 100)
                                                        : $urandom();
          endcase
        end
        left--;
        beat.now_ms = now;
        offer_poll(beat, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (due_events.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, due_events.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("button_debounce_long_press regression: pass");
    end else begin
      $display("button_debounce_long_press regression: fail");
    end
    $finish;
  end

endmodule
